### rtl/kmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared constants and types for the k-means clustering engine.
// ----------------------------------------------------------------------------
package kmc_pkg;

	localparam int MaxPoints   = 1024;
	localparam int MaxClusters = 16;
	localparam int MaxDims     = 8;

	localparam int PtW   = $clog2(MaxPoints);          // 10
	localparam int ClW   = $clog2(MaxClusters);        // 4
	localparam int DimW  = $clog2(MaxDims);            // 3
	localparam int CntW  = PtW + 1;                    // 11
	localparam int LblW  = ClW + 1;                    // 5
	localparam int SumW  = 48;
	localparam int DistW = 70;
	localparam int IterW = 16;

	typedef enum logic [1:0] {
		CMD_LOAD_POINT  = 2'd0,
		CMD_LOAD_CENTER = 2'd1,
		CMD_RUN         = 2'd2,
		CMD_READ        = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CONVERGED = 2'd0,
		ST_ITER_LIM  = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_LABEL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_NUM_CLUSTERS = 2'd0,
		REG_NUM_DIMS     = 2'd1,
		REG_NUM_POINTS   = 2'd2,
		REG_MAX_ITER     = 2'd3
	} reg_idx_t;

	typedef enum logic [17:0] {
		S_CLR  = 18'h00001,
		S_IDLE = 18'h00002,
		S_RDL  = 18'h00004,
		S_DRD  = 18'h00008,
		S_DDIF = 18'h00010,
		S_DM0  = 18'h00020,
		S_DM1  = 18'h00040,
		S_DM2  = 18'h00080,
		S_DM3  = 18'h00100,
		S_DCMP = 18'h00200,
		S_LBL  = 18'h00400,
		S_SRD  = 18'h00800,
		S_SWR  = 18'h01000,
		S_CHK  = 18'h02000,
		S_URD  = 18'h04000,
		S_ULD  = 18'h08000,
		S_UDIV = 18'h10000,
		S_UWR  = 18'h20000
	} state_t;

endpackage

### rtl/kmeans_clustering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_clustering
// Lloyd k-means over signed Q16.16 points held in on-chip RAM.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          content
//  s_*       in   s_tvalid/s_tready  command word (load, run, read)
//  m_*       out  m_tvalid/m_tready  result word (run status or label)
//  cfg_*     in   cfg_we             register write, no read-back
//
//  After reset the label RAM is swept to zero, with s_tready low meanwhile.
//  Load words are written straight from the input word; a label read goes
//  through S_RDL to the result register. The length of a run iteration is
//  set by the single shared squarer (3 partial products per coordinate)
//  and the bit-serial divider (48 steps per mean).
//  The result register decouples the sides: a load may be taken while a
//  result waits; s_tready is low only while a command is being worked on
//  or a result would have nowhere to go.
module kmeans_clustering
	import kmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // command[1:0], row_index[11:2], dim_index[14:12],
	                              // coord_value[46:15], zero[47]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // status[1:0], iterations_used[17:2],
	                              // cluster_label[22:18], point_index[32:23], zero[39:33]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// configuration
	logic [4:0]  num_clusters_q;
	logic [3:0]  num_dims_q;
	logic [10:0] num_points_q;
	logic [15:0] max_iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= 5'd2;
			num_dims_q     <= 4'd2;
			num_points_q   <= 11'd1;
			max_iter_q     <= 16'd100;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_NUM_CLUSTERS: num_clusters_q <= cfg_wdata[4:0];
				REG_NUM_DIMS:     num_dims_q     <= cfg_wdata[3:0];
				REG_NUM_POINTS:   num_points_q   <= cfg_wdata[10:0];
				REG_MAX_ITER:     max_iter_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// saturated working values, as last index
	logic [ClW-1:0]  k_last;
	logic [DimW-1:0] p_last;
	logic [PtW-1:0]  n_last;
	logic [IterW-1:0] lim;

	always_comb begin
		if (num_clusters_q == 5'd0)        k_last = '0;
		else if (num_clusters_q > 5'd16)   k_last = '1;
		else                               k_last = ClW'(num_clusters_q - 5'd1);
		if (num_dims_q == 4'd0)            p_last = '0;
		else if (num_dims_q > 4'd8)        p_last = '1;
		else                               p_last = DimW'(num_dims_q - 4'd1);
		if (num_points_q == 11'd0)         n_last = '0;
		else if (num_points_q > 11'd1024)  n_last = '1;
		else                               n_last = PtW'(num_points_q - 11'd1);
		lim = (max_iter_q == '0) ? 16'd1 : max_iter_q;
	end

	// input word fields
	cmd_t               in_cmd;
	logic [PtW-1:0]     in_row;
	logic [DimW-1:0]    in_dim;
	logic [31:0]        in_val;
	assign in_cmd = cmd_t'(s_tdata[1:0]);
	assign in_row = s_tdata[11:2];
	assign in_dim = s_tdata[14:12];
	assign in_val = s_tdata[46:15];

	state_t state_q;
	logic   in_acc;
	// loads produce no result, so they pass while a result word waits
	assign s_tready = (state_q == S_IDLE) &&
	                  (!m_tvalid || m_tready ||
	                   in_cmd == CMD_LOAD_POINT || in_cmd == CMD_LOAD_CENTER);
	assign in_acc   = s_tvalid && s_tready;

	// counters and working registers
	logic [PtW-1:0]   i_q;
	logic [ClW-1:0]   c_q;
	logic [DimW-1:0]  d_q;
	logic [IterW-1:0] it_q;
	logic [IterW-1:0] iter_used_q;
	logic [PtW-1:0]   clr_q;
	logic [PtW-1:0]   row_q;
	logic [ClW-1:0]   best_idx_q;
	logic [DistW-1:0] acc_q;
	logic [DistW-1:0] best_q;
	logic [DistW-1:0] prod_q;
	logic [32:0]      mag_q;
	logic             same_q;
	logic [SumW-1:0]  quot_q;
	logic [CntW-1:0]  rem_q;
	logic             neg_q;
	logic [5:0]       step_q;

	// memories
	logic [31:0]     point_mem [MaxPoints*MaxDims];
	logic [31:0]     center_mem[MaxClusters*MaxDims];
	logic [SumW-1:0] sum_mem   [MaxClusters*MaxDims];
	logic [LblW-1:0] label_mem [MaxPoints];
	logic [MaxClusters*MaxDims-1:0] sum_vld_q;
	logic [CntW-1:0] counts_q[MaxClusters];

	logic [31:0]     pt_rd_q, ct_rd_q;
	logic [SumW-1:0] sum_rd_q;
	logic [LblW-1:0] lbl_rd_q;

	// point RAM: load writes, reads at {i, d}
	logic pt_we;
	assign pt_we = in_acc && in_cmd == CMD_LOAD_POINT;
	always_ff @(posedge clk) begin
		if (pt_we) point_mem[{in_row, in_dim}] <= in_val;
		pt_rd_q <= point_mem[{i_q, d_q}];
	end

	// centre RAM
	logic        ct_we;
	logic [6:0]  ct_wa;
	logic [31:0] ct_wd;
	logic [31:0] new_ctr;
	always_comb begin
		ct_we = 1'b0;
		ct_wa = {c_q, d_q};
		ct_wd = new_ctr;
		if (in_acc && in_cmd == CMD_LOAD_CENTER && in_row < PtW'(MaxClusters)) begin
			ct_we = 1'b1;
			ct_wa = {in_row[ClW-1:0], in_dim};
			ct_wd = in_val;
		end else if (state_q == S_UWR) begin
			ct_we = 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (ct_we) center_mem[ct_wa] <= ct_wd;
		ct_rd_q <= center_mem[{c_q, d_q}];
	end

	// sum RAM, valid bits cleared per iteration
	logic [6:0]      sum_ra, sum_wa;
	logic [SumW-1:0] sum_old, sum_new;
	logic            sum_rvld_q;
	assign sum_ra  = (state_q == S_SRD) ? {best_idx_q, d_q} : {c_q, d_q};
	assign sum_wa  = {best_idx_q, d_q};
	assign sum_old = sum_rvld_q ? sum_rd_q : '0;
	assign sum_new = sum_old + {{(SumW-32){pt_rd_q[31]}}, pt_rd_q};
	always_ff @(posedge clk) begin
		if (state_q == S_SWR) sum_mem[sum_wa] <= sum_new;
		sum_rd_q <= sum_mem[sum_ra];
	end

	// label RAM, swept to zero after reset
	logic            lbl_we;
	logic [PtW-1:0]  lbl_wa, lbl_ra;
	logic [LblW-1:0] lbl_wd;
	always_comb begin
		lbl_we = 1'b0;
		lbl_wa = i_q;
		lbl_wd = LblW'(best_idx_q) + LblW'(1);
		if (state_q == S_CLR) begin
			lbl_we = 1'b1;
			lbl_wa = clr_q;
			lbl_wd = '0;
		end else if (state_q == S_LBL) begin
			lbl_we = 1'b1;
		end
	end
	assign lbl_ra = in_row;
	always_ff @(posedge clk) begin
		if (lbl_we) label_mem[lbl_wa] <= lbl_wd;
		lbl_rd_q <= label_mem[lbl_ra];
	end

	// member count select
	logic [CntW-1:0] cnt_sel;
	assign cnt_sel = counts_q[(state_q == S_LBL) ? best_idx_q : c_q];

	// distance datapath
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [15:0]        mag_lo;
	logic [16:0]        mag_hi;
	assign diff   = $signed({pt_rd_q[31], pt_rd_q}) - $signed({ct_rd_q[31], ct_rd_q});
	assign mag    = diff[32] ? 33'(-diff) : 33'(diff);
	assign mag_lo = mag_q[15:0];
	assign mag_hi = mag_q[32:16];

	// divider step: restoring, one quotient bit per cycle
	logic [CntW:0]   trial;
	logic [SumW-1:0] sum_mag;
	assign trial   = {rem_q, quot_q[SumW-1]};
	assign sum_mag = sum_rd_q[SumW-1] ? SumW'(-sum_rd_q) : sum_rd_q;

	logic [SumW-1:0] q_signed;
	assign q_signed = neg_q ? SumW'(-quot_q) : quot_q;
	assign new_ctr  = q_signed[31:0];

	logic last_d, last_c, last_i;
	assign last_d = (d_q == p_last);
	assign last_c = (c_q == k_last);
	assign last_i = (i_q == n_last);

	// result register
	logic [1:0]      out_status_q;
	logic [LblW-1:0] out_label_q;
	logic [PtW-1:0]  out_pidx_q;
	assign m_tdata = {7'd0, out_pidx_q, out_label_q, iter_used_q, out_status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			i_q         <= '0;
			c_q         <= '0;
			d_q         <= '0;
			it_q        <= '0;
			iter_used_q <= '0;
			m_tvalid    <= 1'b0;
			sum_vld_q   <= '0;
			sum_rvld_q  <= 1'b0;
			same_q      <= 1'b1;
			step_q      <= '0;
			for (int j = 0; j < MaxClusters; j++) counts_q[j] <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			sum_rvld_q <= sum_vld_q[sum_ra];
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PtW'(1);
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						row_q <= in_row;
						priority if (in_cmd == CMD_READ) begin
							state_q <= S_RDL;
						end else if (in_cmd == CMD_RUN) begin
							it_q      <= 16'd1;
							i_q       <= '0;
							c_q       <= '0;
							d_q       <= '0;
							acc_q     <= '0;
							sum_vld_q <= '0;
							for (int j = 0; j < MaxClusters; j++) counts_q[j] <= '0;
							state_q   <= S_DRD;
						end
					end
				end
				S_RDL: begin
					m_tvalid     <= 1'b1;
					out_status_q <= ST_LABEL;
					out_label_q  <= lbl_rd_q;
					out_pidx_q   <= row_q;
					state_q      <= S_IDLE;
				end
				S_DRD:  state_q <= S_DDIF;
				S_DDIF: begin
					mag_q   <= mag;
					state_q <= S_DM0;
				end
				S_DM0: begin
					prod_q  <= DistW'(mag_lo * mag_lo);
					state_q <= S_DM1;
				end
				S_DM1: begin
					acc_q   <= acc_q + prod_q;
					prod_q  <= DistW'(mag_hi * mag_lo) << 17;
					state_q <= S_DM2;
				end
				S_DM2: begin
					acc_q   <= acc_q + prod_q;
					prod_q  <= DistW'(mag_hi * mag_hi) << 32;
					state_q <= S_DM3;
				end
				S_DM3: begin
					acc_q <= acc_q + prod_q;
					if (last_d) begin
						state_q <= S_DCMP;
					end else begin
						d_q     <= d_q + DimW'(1);
						state_q <= S_DRD;
					end
				end
				S_DCMP: begin
					if (c_q == '0 || acc_q < best_q) begin
						best_q     <= acc_q;
						best_idx_q <= c_q;
					end
					d_q   <= '0;
					acc_q <= '0;
					if (last_c) begin
						state_q <= S_LBL;
					end else begin
						c_q     <= c_q + ClW'(1);
						state_q <= S_DRD;
					end
				end
				S_LBL: begin
					counts_q[best_idx_q] <= cnt_sel + CntW'(1);
					d_q     <= '0;
					state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					sum_vld_q[sum_wa] <= 1'b1;
					if (last_d) begin
						d_q <= '0;
						c_q <= '0;
						if (last_i) begin
							state_q <= S_CHK;
						end else begin
							i_q     <= i_q + PtW'(1);
							state_q <= S_DRD;
						end
					end else begin
						d_q     <= d_q + DimW'(1);
						state_q <= S_SRD;
					end
				end
				S_CHK: begin
					priority if (cnt_sel == '0) begin
						m_tvalid     <= 1'b1;
						out_status_q <= ST_EMPTY;
						out_label_q  <= '0;
						out_pidx_q   <= '0;
						iter_used_q  <= it_q;
						state_q      <= S_IDLE;
					end else if (last_c) begin
						c_q     <= '0;
						d_q     <= '0;
						same_q  <= 1'b1;
						state_q <= S_URD;
					end else begin
						c_q <= c_q + ClW'(1);
					end
				end
				S_URD: state_q <= S_ULD;
				S_ULD: begin
					neg_q   <= sum_old[SumW-1];
					quot_q  <= sum_rvld_q ? sum_mag : '0;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= S_UDIV;
				end
				S_UDIV: begin
					if (trial >= {1'b0, cnt_sel}) begin
						rem_q  <= CntW'(trial - {1'b0, cnt_sel});
						quot_q <= {quot_q[SumW-2:0], 1'b1};
					end else begin
						rem_q  <= trial[CntW-1:0];
						quot_q <= {quot_q[SumW-2:0], 1'b0};
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'(SumW - 1)) state_q <= S_UWR;
				end
				S_UWR: begin
					if (new_ctr != ct_rd_q) same_q <= 1'b0;
					priority if (!(last_c && last_d)) begin
						if (last_d) begin
							d_q <= '0;
							c_q <= c_q + ClW'(1);
						end else begin
							d_q <= d_q + DimW'(1);
						end
						state_q <= S_URD;
					end else if (same_q && new_ctr == ct_rd_q) begin
						m_tvalid     <= 1'b1;
						out_status_q <= ST_CONVERGED;
						out_label_q  <= '0;
						out_pidx_q   <= '0;
						iter_used_q  <= it_q;
						state_q      <= S_IDLE;
					end else if (it_q == lim) begin
						m_tvalid     <= 1'b1;
						out_status_q <= ST_ITER_LIM;
						out_label_q  <= '0;
						out_pidx_q   <= '0;
						iter_used_q  <= lim;
						state_q      <= S_IDLE;
					end else begin
						it_q      <= it_q + 16'd1;
						i_q       <= '0;
						c_q       <= '0;
						d_q       <= '0;
						acc_q     <= '0;
						sum_vld_q <= '0;
						for (int j = 0; j < MaxClusters; j++) counts_q[j] <= '0;
						state_q   <= S_DRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
